>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked during reset.
`define KSR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define KSR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ksr_pkg.sv
// Shared constants and types of the Kerr-Schild radius unit.
package ksr_pkg;
  localparam int unsigned CoordW         = 32;
  localparam int unsigned SpinW          = 17;
  localparam int unsigned RadiusW        = 32;
  localparam int unsigned FracBitsDef    = 16;
  localparam int unsigned ApbAddrW       = 3;
  localparam int unsigned ApbDataW       = 32;
  localparam int unsigned SqW            = 64;
  localparam int unsigned InnerW         = 128;

  localparam logic [ApbAddrW-1:0] AddrSpinSq = 3'd0;

  typedef logic [CoordW-1:0]  coord_t;
  typedef logic [SpinW-1:0]   spin_t;
  typedef logic [RadiusW-1:0] radius_t;
  typedef logic [SqW-1:0]     sq_t;
  typedef logic [InnerW-1:0]  inner_t;

  typedef struct packed {
    logic valid;
    logic en;
  } pipe_ctl_t;
endpackage

>>> hw/rtl/ksr_front.sv
// Front end: squares, RR - a^2 and the radicand of the inner root.
module ksr_front #(
  parameter int unsigned FRAC_BITS = ksr_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ksr_pkg::pipe_ctl_t ctl_i,
  input  ksr_pkg::coord_t    coord_x_i,
  input  ksr_pkg::coord_t    coord_y_i,
  input  ksr_pkg::coord_t    coord_z_i,
  input  logic               end_i,
  input  ksr_pkg::spin_t     spin_i,
  output logic               valid_o,
  output ksr_pkg::inner_t    inner_o,
  output ksr_pkg::sq_t       mag_o,
  output logic               neg_o,
  output logic               end_o
);
  import ksr_pkg::*;

  localparam int unsigned NStg = 7;

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] end_q;
  logic            en;

  // stage 1
  coord_t ax_q, ay_q, az_q;
  spin_t  spin_q;
  // stage 2
  sq_t         xx_q, yy_q, zz_q;
  logic [48:0] sa_q;
  coord_t      az2_q;
  // stage 3
  sq_t         rr_q;
  logic [63:0] pl_q;
  logic [48:0] ph_q;
  // stage 4
  sq_t    mag4_q;
  logic   neg4_q;
  inner_t four4_q;
  // stage 5
  sq_t    ll_q, lh_q, hl_q, hh_q;
  inner_t four5_q;
  sq_t    mag5_q;
  logic   neg5_q;
  // stage 6
  inner_t      lo6_q;
  logic [64:0] mid6_q;
  sq_t         hh6_q, mag6_q;
  logic        neg6_q;
  // stage 7
  inner_t inner7_q;
  sq_t    mag7_q;
  logic   neg7_q;

  sq_t         a2;
  logic [80:0] prod4;

  function automatic coord_t abs_c(input coord_t v);
    abs_c = v[CoordW-1] ? coord_t'(~v + 1'b1) : v;
  endfunction

  assign en = ctl_i.en;
  assign a2 = sq_t'(rr_q) - sq_t'(rr_q) + (sq_t'(spin_q) << FRAC_BITS);
  assign prod4 = {ph_q, 32'b0} + 81'(pl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      end_q   <= {end_q[NStg-2:0], end_i};
      ax_q    <= abs_c(coord_x_i);
      ay_q    <= abs_c(coord_y_i);
      az_q    <= abs_c(coord_z_i);
      spin_q  <= spin_i;
      xx_q    <= sq_t'(ax_q) * sq_t'(ax_q);
      yy_q    <= sq_t'(ay_q) * sq_t'(ay_q);
      zz_q    <= sq_t'(az_q) * sq_t'(az_q);
      sa_q    <= 49'(spin_q) * 49'(az_q);
      az2_q   <= az_q;
      rr_q    <= xx_q + yy_q + zz_q;
      pl_q    <= 64'(sa_q[31:0]) * 64'(az2_q);
      ph_q    <= 49'(sa_q[48:32]) * 49'(az2_q);
      if (rr_q >= a2) begin
        mag4_q <= rr_q - a2;
        neg4_q <= 1'b0;
      end else begin
        mag4_q <= a2 - rr_q;
        neg4_q <= 1'b1;
      end
      four4_q <= inner_t'(prod4) << (FRAC_BITS + 2);
      ll_q    <= sq_t'(mag4_q[31:0]) * sq_t'(mag4_q[31:0]);
      lh_q    <= sq_t'(mag4_q[31:0]) * sq_t'(mag4_q[63:32]);
      hl_q    <= sq_t'(mag4_q[63:32]) * sq_t'(mag4_q[31:0]);
      hh_q    <= sq_t'(mag4_q[63:32]) * sq_t'(mag4_q[63:32]);
      four5_q <= four4_q;
      mag5_q  <= mag4_q;
      neg5_q  <= neg4_q;
      lo6_q   <= inner_t'(ll_q) + four5_q;
      mid6_q  <= 65'(lh_q) + 65'(hl_q);
      hh6_q   <= hh_q;
      mag6_q  <= mag5_q;
      neg6_q  <= neg5_q;
      inner7_q <= lo6_q + (inner_t'(mid6_q) << 32) + (inner_t'(hh6_q) << 64);
      mag7_q   <= mag6_q;
      neg7_q   <= neg6_q;
    end
  end

  assign valid_o = vld_q[NStg-1];
  assign end_o   = end_q[NStg-1];
  assign inner_o = inner7_q;
  assign mag_o   = mag7_q;
  assign neg_o   = neg7_q;
endmodule

>>> hw/rtl/ksr_sqrt.sv
// Pipelined truncated integer square root, one result bit per stage.
module ksr_sqrt #(
  parameter int unsigned N  = 32,
  parameter int unsigned SW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ksr_pkg::pipe_ctl_t ctl_i,
  input  logic [2*N-1:0]     rad_i,
  input  logic [SW-1:0]      side_i,
  output logic               valid_o,
  output logic [N-1:0]       root_o,
  output logic [SW-1:0]      side_o
);
  import ksr_pkg::*;

  logic [N-1:0]   vld_q;
  logic [N+1:0]   rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [2*N-1:0] rad_q  [N];
  logic [SW-1:0]  side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stg
    logic [N+1:0]   rem_in, r2, trial;
    logic [N-1:0]   root_in;
    logic [2*N-1:0] rad_in;
    logic [SW-1:0]  side_in;
    logic           vld_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = ctl_i.valid;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign r2    = {rem_in[N-1:0], rad_in[2*N-1:2*N-2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rad_q[k]  <= rad_in << 2;
        side_q[k] <= side_in;
        if (r2 >= trial) begin
          rem_q[k]  <= r2 - trial;
          root_q[k] <= {root_in[N-2:0], 1'b1};
        end else begin
          rem_q[k]  <= r2;
          root_q[k] <= {root_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];
endmodule

>>> hw/rtl/kerr_schild_radius.sv
// Kerr-Schild radius unit: top level with register port and pipeline.
// Takes one grid point per clock and returns r = sqrt(((RR-a^2) +
// sqrt((RR-a^2)^2 + 4a^2z^2))/2), RR = x^2+y^2+z^2, unsigned with
// COORD_FRAC_BITS fraction bits. The pipeline has 7 front-end stages
// (squares and split wide products), a 64-stage inner root, one halving stage
// and a 32-stage outer root, each root stage settling one bit. A stalled
// result freezes the whole pipeline; otherwise one request enters per cycle.
// spin_squared sits at byte address 0 and should be written while idle.
`include "assert_macros.svh"

module kerr_schild_radius #(
  parameter int unsigned COORD_FRAC_BITS = ksr_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ksr_pkg::ApbAddrW-1:0]      paddr,
  input  logic [ksr_pkg::ApbDataW-1:0]      pwdata,
  output logic [ksr_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  ksr_pkg::coord_t                   coord_x_i,
  input  ksr_pkg::coord_t                   coord_y_i,
  input  ksr_pkg::coord_t                   coord_z_i,
  input  logic                              grid_end_in_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output ksr_pkg::radius_t                  radius_o,
  output logic                              grid_end_out_o
);
  import ksr_pkg::*;

  spin_t      spin_q;
  logic       wr;
  logic       en;
  pipe_ctl_t  ctl_in, ctl_s1, ctl_h, ctl_s2;

  logic   f_vld, f_neg, f_end;
  inner_t f_inner;
  sq_t    f_mag;

  logic         s1_vld;
  logic [63:0]  s1_root;
  logic [65:0]  s1_side;

  logic         h_vld_q, h_end_q;
  sq_t          h_half_q;
  logic [64:0]  sum;

  logic         s2_vld;
  logic [31:0]  s2_root;
  logic         s2_end;

  assign pready = 1'b1;
  assign prdata = ApbDataW'(spin_q);
  assign wr     = psel && penable && pwrite && (paddr == AddrSpinSq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_q <= '0;
    end else if (wr) begin
      spin_q <= pwdata[SpinW-1:0];
    end
  end

  assign en      = !(s2_vld && stall_i);
  assign stall_o = !en;

  assign ctl_in = '{valid: valid_i, en: en};
  assign ctl_s1 = '{valid: f_vld, en: en};
  assign ctl_h  = '{valid: h_vld_q, en: en};
  assign ctl_s2 = ctl_h;

  ksr_front #(.FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .ctl_i     (ctl_in),
    .coord_x_i,
    .coord_y_i,
    .coord_z_i,
    .end_i     (grid_end_in_i),
    .spin_i    (spin_q),
    .valid_o   (f_vld),
    .inner_o   (f_inner),
    .mag_o     (f_mag),
    .neg_o     (f_neg),
    .end_o     (f_end)
  );

  ksr_sqrt #(.N(64), .SW(66)) u_sqrt_inner (
    .clk_i, .rst_ni,
    .ctl_i   (ctl_s1),
    .rad_i   (f_inner),
    .side_i  ({f_end, f_neg, f_mag}),
    .valid_o (s1_vld),
    .root_o  (s1_root),
    .side_o  (s1_side)
  );

  assign sum = 65'(s1_side[63:0]) + 65'(s1_root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (en) begin
      h_vld_q <= s1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_end_q  <= s1_side[65];
      h_half_q <= s1_side[64] ? ((s1_root - s1_side[63:0]) >> 1) : sum[64:1];
    end
  end

  ksr_sqrt #(.N(32), .SW(1)) u_sqrt_outer (
    .clk_i, .rst_ni,
    .ctl_i   (ctl_s2),
    .rad_i   (h_half_q),
    .side_i  (h_end_q),
    .valid_o (s2_vld),
    .root_o  (s2_root),
    .side_o  (s2_end)
  );

  assign valid_o        = s2_vld;
  assign radius_o       = s2_root;
  assign grid_end_out_o = s2_end;

  `KSR_ASSERT(a_stall_map, clk_i, rst_ni, stall_o == (valid_o && stall_i), "stall mismatch")
  `KSR_ASSERT(a_spin_hold, clk_i, rst_ni, !$past(wr) |-> $stable(spin_q), "spin changed")
  `KSR_ASSERT(a_frozen, clk_i, rst_ni, (valid_o && stall_i) |=> (valid_o && $stable(radius_o) && $stable(h_half_q)), "pipe moved while stalled")
endmodule

>>> verif/kerr_schild_radius_test.sv
// Self-checking testbench for the Kerr-Schild radius unit.
module kerr_schild_radius_test;
  import ksr_pkg::*;

  localparam int unsigned FracBits   = FracBitsDef;
  localparam int unsigned Latency    = 104;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned RandItems  = 1100;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
    logic   known;
    radius_t r;
  } point_t;

  typedef struct {
    radius_t r;
    logic    last;
  } radius_exp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;
  logic valid_i = 1'b0;
  logic stall_o;
  coord_t coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic grid_end_in_i = 1'b0;
  logic valid_o;
  logic stall_i = 1'b0;
  radius_t radius_o;
  logic grid_end_out_o;

  kerr_schild_radius dut (.*);

  always #2 clk_i = ~clk_i;

  spin_t spin_sq;
  radius_exp_t radius_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_stall_on = 1'b1;

  function automatic logic [63:0] coord_mag(coord_t c);
    return c[CoordW-1] ? 64'(-$signed({1'b1, c})) : {32'd0, c};
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= v) res = cand;
    end
    return res;
  endfunction

  function automatic radius_t ks_radius(coord_t x, coord_t y, coord_t z, spin_t a2s);
    logic [127:0] ax, ay, az, zz, rr, a2, mag, s, half;
    logic neg;
    ax = coord_mag(x);
    ay = coord_mag(y);
    az = coord_mag(z);
    zz = az * az;
    rr = ax * ax + ay * ay + zz;
    a2 = 128'(a2s) << FracBits;
    neg = rr < a2;
    mag = neg ? a2 - rr : rr - a2;
    s = isqrt(mag * mag + ((a2 << 2) * zz));
    half = neg ? (s - mag) >> 1 : (mag + s) >> 1;
    return radius_t'(isqrt(half));
  endfunction

  task automatic apb_write(logic [ApbAddrW-1:0] addr, logic [ApbDataW-1:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrSpinSq) spin_sq = spin_t'(data);
  endtask

  task automatic drain_pipe();
    while (radius_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic send_point(point_t p);
    radius_exp_t e;
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    coord_x_i <= p.x; coord_y_i <= p.y; coord_z_i <= p.z; grid_end_in_i <= p.last;
    do @(posedge clk_i); while (stall_o);
    e.r = p.known ? p.r : ks_radius(p.x, p.y, p.z, spin_sq);
    e.last = p.last;
    radius_q.push_back(e);
  endtask

  task automatic end_burst();
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result checking against the oldest expectation.
  always @(posedge clk_i) begin
    radius_exp_t e;
    if (rst_ni && valid_o && !stall_i) begin
      if (radius_q.size() == 0) begin
        $error("unexpected result radius=%h", radius_o);
        errors++;
      end else begin
        e = radius_q.pop_front();
        if (radius_o !== e.r) begin
          $error("radius expected %h got %h", e.r, radius_o);
          errors++;
        end
        if (grid_end_out_o !== e.last) begin
          $error("grid_end_out expected %b got %b", e.last, grid_end_out_o);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    if (!rx_stall_on) stall_i <= 1'b0;
    else if ($urandom_range(0, 9) < 3)
      stall_i <= ($urandom_range(0, 29) == 0) ? 1'b1 : ~stall_i;
    else if ($urandom_range(0, 49) == 0) stall_i <= 1'b1;
    else stall_i <= 1'b0;
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom());
      1: return coord_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      2: return coord_t'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      default: return coord_t'($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff);
    endcase
  endfunction

  localparam int NDir = 14;
  point_t dir_tab[NDir];
  spin_t spin_set[5] = '{17'd0, 17'd65536, 17'h1ffff, 17'd1, 17'd32768};

  initial begin
    point_t p;
    int m;
    spin_sq = '0;
    // x, y, z, last, known, r
    dir_tab[0]  = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 32'd0};
    dir_tab[1]  = '{32'h0001_0000, 32'd0, 32'd0, 1'b1, 1'b1, 32'h0001_0000};
    dir_tab[2]  = '{32'hffff_0000, 32'd0, 32'd0, 1'b0, 1'b1, 32'h0001_0000};
    dir_tab[3]  = '{32'h8000_0000, 32'd0, 32'd0, 1'b0, 1'b1, 32'h8000_0000};
    dir_tab[4]  = '{32'h7fff_ffff, 32'd0, 32'd0, 1'b1, 1'b1, 32'h7fff_ffff};
    dir_tab[5]  = '{32'd0, 32'd0, 32'h0003_0000, 1'b0, 1'b1, 32'h0003_0000};
    dir_tab[6]  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, '0};
    dir_tab[7]  = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0, '0};
    dir_tab[8]  = '{32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 1'b0, 1'b0, '0};
    dir_tab[9]  = '{32'h0000_4000, 32'h0000_4000, 32'h0000_2000, 1'b0, 1'b0, '0};
    dir_tab[10] = '{32'h0000_8000, 32'd0, 32'h0000_8000, 1'b1, 1'b0, '0};
    dir_tab[11] = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0, '0};
    dir_tab[12] = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b1, 1'b0, '0};
    dir_tab[13] = '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, 1'b0, '0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset spin value first, then every other spin setting.
    for (int s = 0; s < 5; s++) begin
      if (s > 0) begin
        drain_pipe();
        apb_write(AddrSpinSq, ApbDataW'(spin_set[s]));
        // out-of-range index writes should be ignored
        apb_write(ApbAddrW'(4), 32'h1_ffff);
      end
      for (int i = 0; i < NDir; i++) begin
        p = dir_tab[i];
        if (s > 0) p.known = 1'b0;
        send_point(p);
      end
      end_burst();
    end

    for (int i = 0; i < RandItems; i++) begin
      if (i % 220 == 219) begin
        end_burst();
        drain_pipe();
        apb_write(AddrSpinSq, ApbDataW'($urandom_range(0, 3) == 0 ? spin_set[$urandom_range(0, 4)]
                                                     : spin_t'($urandom())));
      end
      if (i == 500) rx_stall_on = 1'b0;
      if (i == 700) rx_stall_on = 1'b1;
      if (i == 400) begin
        end_burst();
        while (radius_q.size() != 0) @(posedge clk_i);
      end
      m = $urandom_range(0, 3);
      p.x = rand_coord(m); p.y = rand_coord(m); p.z = rand_coord($urandom_range(0, 3));
      p.last = ($urandom_range(0, 15) == 0);
      p.known = 1'b0; p.r = '0;
      send_point(p);
    end
    end_burst();

    while (radius_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> kerr_schild_radius.f
+incdir+hw/rtl
hw/rtl/ksr_pkg.sv
hw/rtl/ksr_front.sv
hw/rtl/ksr_sqrt.sv
hw/rtl/kerr_schild_radius.sv
verif/kerr_schild_radius_test.sv
